>>> rtl/dmtp_pkg.sv
`default_nettype none

package dmtp_pkg;

  // Character codes recognised by the grammar.
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  localparam int unsigned WholeW  = 57;
  localparam int unsigned FracW   = 7;
  localparam int unsigned AmountW = 63;

  // Largest whole part that can still take a digit 0..8; for digit 9 it must be one less.
  localparam logic [WholeW-1:0] WholeLimit = 57'd9223372036854775;
  // Largest whole part that can ever be reached (the signed 64-bit maximum over 100).
  localparam logic [WholeW-1:0] WholeMax   = 57'd92233720368547758;
  // Fraction above which the largest whole part overflows the signed 64-bit range.
  localparam logic [FracW-1:0]  FracMaxAtTop = 7'd7;

  // One request held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] character;
  } dmtp_req_t;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CharZero) && (c <= CharNine);
  endfunction

  // True when taking digit d would push the amount past the signed 64-bit range.
  function automatic logic digit_overflows(input logic [WholeW-1:0] whole,
                                           input logic [3:0] d);
    digit_overflows = (whole > WholeLimit) || ((whole == WholeLimit) && (d == 4'd9));
  endfunction

endpackage

`default_nettype wire

>>> rtl/dmtp_in_reg.sv
`default_nettype none

module dmtp_in_reg
  import dmtp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic [7:0] character_i,
  output logic           in_stall_o,
  input  wire logic      take_i,
  output dmtp_req_t      req_o
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       accept;

  // The register is free when empty or when its request moves on this cycle.
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  // Valid flag under reset; the character itself needs none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= character_i;
    end
  end

  assign req_o.valid     = valid_q;
  assign req_o.character = char_q;

endmodule

`default_nettype wire

>>> rtl/dmtp_core.sv
`default_nettype none

module dmtp_core
  import dmtp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dmtp_req_t         req_i,
  output logic                   take_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   ok_o,
  output logic [AmountW-1:0]     amount_hundredths_o
);

  typedef enum logic [2:0] {
    PhLead  = 3'd0,
    PhSign  = 3'd1,
    PhWhole = 3'd2,
    PhSep   = 3'd3,
    PhFrac1 = 3'd4,
    PhFrac2 = 3'd5,
    PhTrail = 3'd6,
    PhError = 3'd7
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [WholeW-1:0]   whole_q, whole_d;
  logic [FracW-1:0]    frac_q, frac_d;
  logic                res_valid_q, res_valid_d;
  logic                ok_q, ok_d;
  logic [AmountW-1:0]  amount_q, amount_d;

  logic [7:0]          c;
  logic [3:0]          d;
  logic                is_nul, dig, blank, sep;
  logic [WholeW-1:0]   whole_next;
  logic [FracW-1:0]    frac_tens;
  logic                ends_ok, nonzero, too_big;
  logic [63:0]         total;

  assign c      = req_i.character;
  assign d      = 4'(c - CharZero);
  assign is_nul = (c == CharNul);
  assign dig    = is_digit(c);
  assign blank  = is_blank(c);
  assign sep    = (c == CharDot) || (c == CharComma);

  // A terminator needs a free result slot; every other character moves on at once.
  assign take_o = req_i.valid && !(is_nul && res_valid_q && out_stall_i);

  // Times ten by shift and add, and the first fraction digit (tenths) scaled to hundredths.
  assign whole_next = {whole_q[WholeW-4:0], 3'b000} + {whole_q[WholeW-2:0], 1'b0}
                    + {{(WholeW-4){1'b0}}, d};
  assign frac_tens  = {d, 3'b000} + {2'b00, d, 1'b0};

  // Final amount in hundredths: whole * 100 + fraction.
  assign total = {1'b0, whole_q, 6'b0} + {2'b0, whole_q, 5'b0} + {5'b0, whole_q, 2'b0}
               + {57'b0, frac_q};
  assign ends_ok = (phase_q == PhWhole) || (phase_q == PhFrac1) ||
                   (phase_q == PhFrac2) || (phase_q == PhTrail);
  assign nonzero = (whole_q != '0) || (frac_q != '0);
  assign too_big = (whole_q == WholeMax) && (frac_q > FracMaxAtTop);

  // Phase transitions and digit accumulation.
  always_comb begin
    phase_d = phase_q;
    whole_d = whole_q;
    frac_d  = frac_q;
    if (take_o) begin
      if (is_nul) begin
        phase_d = PhLead;
        whole_d = '0;
        frac_d  = '0;
      end else begin
        unique case (phase_q)
          PhLead: begin
            if (blank) begin
              phase_d = PhLead;
            end else if (c == CharPlus) begin
              phase_d = PhSign;
            end else if (dig && !digit_overflows(whole_q, d)) begin
              phase_d = PhWhole;
              whole_d = whole_next;
            end else begin
              phase_d = PhError;
            end
          end
          PhSign, PhWhole: begin
            if (dig && !digit_overflows(whole_q, d)) begin
              phase_d = PhWhole;
              whole_d = whole_next;
            end else if (phase_q == PhWhole && sep) begin
              phase_d = PhSep;
            end else if (phase_q == PhWhole && blank) begin
              phase_d = PhTrail;
            end else begin
              phase_d = PhError;
            end
          end
          PhSep: begin
            if (dig) begin
              phase_d = PhFrac1;
              frac_d  = frac_tens;
            end else begin
              phase_d = PhError;
            end
          end
          PhFrac1: begin
            if (dig) begin
              phase_d = PhFrac2;
              frac_d  = frac_q + {3'b000, d};
            end else if (blank) begin
              phase_d = PhTrail;
            end else begin
              phase_d = PhError;
            end
          end
          PhFrac2, PhTrail: begin
            phase_d = blank ? PhTrail : PhError;
          end
          PhError: begin
            phase_d = PhError;
          end
        endcase
      end
    end
  end

  // Result register: loaded by a terminator, emptied when the consumer takes it.
  always_comb begin
    res_valid_d = res_valid_q;
    ok_d        = ok_q;
    amount_d    = amount_q;
    if (res_valid_q && !out_stall_i) begin
      res_valid_d = 1'b0;
    end
    if (take_o && is_nul) begin
      res_valid_d = 1'b1;
      ok_d        = ends_ok && nonzero && !too_big;
      amount_d    = (ends_ok && nonzero && !too_big) ? total[AmountW-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLead;
      whole_q     <= '0;
      frac_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      whole_q     <= whole_d;
      frac_q      <= frac_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q     <= ok_d;
    amount_q <= amount_d;
  end

  assign out_valid_o         = res_valid_q;
  assign ok_o                = ok_q;
  assign amount_hundredths_o = amount_q;

`ifndef SYNTHESIS
  // A failed text always reports a zero amount.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !ok_q) |-> (amount_q == '0))
    else $error("failed result carries a non-zero amount");

  // A good result is never zero.
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && ok_q) |-> (amount_q != '0))
    else $error("good result carries a zero amount");

  // The whole part never climbs past the largest reachable value.
  a_whole_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    whole_q <= WholeMax)
    else $error("whole part out of range");

  // A terminator returns the parser to its start phase with cleared state.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && is_nul) |=> (phase_q == PhLead && whole_q == '0 && frac_q == '0
                            && res_valid_q))
    else $error("parser did not restart after a terminator");

  // Once in error, only a terminator leaves that phase.
  a_error_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhError && !(take_o && is_nul)) |=> (phase_q == PhError))
    else $error("error phase left without a terminator");
`endif

endmodule

`default_nettype wire

>>> rtl/decimal_money_text_parser.sv
`default_nettype none

// Parses a money amount sent as ASCII text, one character per request, and
// returns it in hundredths. Leading and trailing whitespace (tab to carriage
// return and space), an optional '+', digits and an optional '.' or ',' with
// one or two fraction digits are accepted; a zero byte ends the text and
// produces exactly one result, every other character produces none. A result
// with ok low always carries amount zero: syntax errors, a zero amount and
// anything above the signed 64-bit maximum all fail. The block takes one
// character every cycle: each character passes an input register and then
// one phase update with a multiply-by-ten shift-add into the state and result
// registers, so a result is presented once its terminator has left the input
// register and been loaded into the result register. Only a terminator that
// meets a full, stalled result register holds the input.
module decimal_money_text_parser
  import dmtp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         character_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    ok_o,
  output logic [AmountW-1:0]      amount_hundredths_o
);

  dmtp_req_t req;
  logic      take;

  // Input register.
  dmtp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .character_i (character_i),
    .in_stall_o  (in_stall_o),
    .take_i      (take),
    .req_o       (req)
  );

  // Phase logic, accumulators and result register.
  dmtp_core u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .req_i               (req),
    .take_o              (take),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .ok_o                (ok_o),
    .amount_hundredths_o (amount_hundredths_o)
  );

endmodule

`default_nettype wire

>>> dv/tb_decimal_money_text_parser.sv
`default_nettype none

module tb_decimal_money_text_parser;
  import dmtp_pkg::*;

  // Parser phases as the predictor tracks them.
  typedef enum logic [2:0] {
    PhLead, PhSign, PhWhole, PhSep, PhFrac1, PhFrac2, PhTrail, PhError
  } text_phase_e;

  typedef struct packed {
    logic               ok;
    logic [AmountW-1:0] amount;
  } money_result_t;

  localparam logic [63:0] SignedTop     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned CharsPerPhase = 450;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned MaxReported   = 10;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [7:0]         character_i = CharNul;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               ok_o;
  logic [AmountW-1:0] amount_hundredths_o;

  // Characters waiting to be sent and amounts waiting to come back.
  logic [7:0]    pending_chars[$];
  money_result_t expected_amounts[$];

  // Predictor state.
  text_phase_e       pr_phase = PhLead;
  logic [WholeW-1:0] pr_whole = '0;
  logic [FracW-1:0]  pr_frac  = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  logic [7:0] blank_chars[6]  = '{CharTab, 8'h0A, 8'h0B, 8'h0C, CharCr, CharSpace};
  logic [7:0] syntax_chars[8] = '{CharPlus, CharDot, CharComma, CharSpace,
                                  CharZero, CharNine, CharTab, 8'h35};

  decimal_money_text_parser dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .character_i        (character_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .ok_o               (ok_o),
    .amount_hundredths_o(amount_hundredths_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] digit_char(input int unsigned v);
    digit_char = CharZero + v[7:0];
  endfunction

  // Queues a text followed by its terminating zero byte.
  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
    pending_chars.push_back(CharNul);
  endtask

  // Request driver; every accepted character also steps the predictor.
  always @(posedge clk_i) begin : drive_requests
    logic [7:0]    ch;
    logic [63:0]   d;
    logic [63:0]   total;
    logic          dig;
    logic          blank;
    logic          sep;
    logic          take_digit;
    money_result_t res;

    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        ch    = character_i;
        d     = {56'd0, ch - CharZero};
        dig   = (ch >= CharZero) && (ch <= CharNine);
        blank = (ch == CharSpace) || ((ch >= CharTab) && (ch <= CharCr));
        sep   = (ch == CharDot) || (ch == CharComma);
        take_digit = 1'b0;

        if (ch == CharNul) begin
          // The terminator reports the amount and restarts the parser.
          total      = pr_whole * 64'd100 + pr_frac;
          res.ok     = 1'b0;
          res.amount = '0;
          if ((pr_phase == PhWhole || pr_phase == PhFrac1 || pr_phase == PhFrac2 ||
               pr_phase == PhTrail) && total != 64'd0 && total <= SignedTop) begin
            res.ok     = 1'b1;
            res.amount = total[AmountW-1:0];
          end
          expected_amounts.push_back(res);
          pr_phase = PhLead;
          pr_whole = '0;
          pr_frac  = '0;
        end else begin
          case (pr_phase)
            PhLead: begin
              if (blank) pr_phase = PhLead;
              else if (ch == CharPlus) pr_phase = PhSign;
              else if (dig) take_digit = 1'b1;
              else pr_phase = PhError;
            end
            PhSign: begin
              if (dig) take_digit = 1'b1;
              else pr_phase = PhError;
            end
            PhWhole: begin
              if (dig) take_digit = 1'b1;
              else if (sep) pr_phase = PhSep;
              else if (blank) pr_phase = PhTrail;
              else pr_phase = PhError;
            end
            PhSep: begin
              if (dig) begin
                pr_frac  = d[FracW-1:0] * 7'd10;
                pr_phase = PhFrac1;
              end else begin
                pr_phase = PhError;
              end
            end
            PhFrac1: begin
              if (dig) begin
                pr_frac  = pr_frac + d[FracW-1:0];
                pr_phase = PhFrac2;
              end else if (blank) begin
                pr_phase = PhTrail;
              end else begin
                pr_phase = PhError;
              end
            end
            PhFrac2, PhTrail: begin
              pr_phase = blank ? PhTrail : PhError;
            end
            default: begin
              pr_phase = PhError;
            end
          endcase

          // A digit is refused when it could push the amount past the signed range.
          if (take_digit) begin
            if (pr_whole > (SignedTop / 64'd100 - d) / 64'd10) begin
              pr_phase = PhError;
            end else begin
              pr_whole = pr_whole * 57'd10 + d[WholeW-1:0];
              pr_phase = PhWhole;
            end
          end
        end
      end

      // Present the next character unless the current one is still held.
      if (!in_valid_i || !in_stall_o) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i  <= 1'b1;
          character_i <= pending_chars.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    money_result_t want;

    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_amounts.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("unexpected result: ok=%0b amount=%0d", ok_o, amount_hundredths_o);
        end
      end else begin
        want = expected_amounts.pop_front();
        if (ok_o !== want.ok || amount_hundredths_o !== want.amount) begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("result mismatch: expected ok=%0b amount=%0d, got ok=%0b amount=%0d",
                     want.ok, want.amount, ok_o, amount_hundredths_o);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus: directed texts, then random texts under four idling regimes.
  initial begin : stimulus
    logic [7:0]  text[$];
    logic [7:0]  b;
    string       top_digits;
    int unsigned queued;
    int unsigned shape;
    int unsigned kind;
    int unsigned pos;

    top_digits = "9223372036854775";
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty text, sign alone, zero amount, separator with no fraction digit,
    // a third fraction digit, blanks around a comma amount, and a high byte.
    queue_text("");
    queue_text("+");
    queue_text("0");
    queue_text("1.");
    queue_text("1.234");
    queue_text(" 9,99\t");
    pending_chars.push_back(8'hFF);
    queue_text("5");

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase

      queued = 0;
      while (queued < CharsPerPhase) begin
        text.delete();

        // Well-formed body: blanks, sign, digits, fraction, blanks.
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 3)) text.push_back(blank_chars[$urandom_range(5)]);
        end
        if ($urandom_range(3) == 0) text.push_back(CharPlus);
        shape = $urandom_range(9);
        if (shape == 0) begin
          // Close to the top of the range, where the digit check bites.
          for (int i = 0; i < top_digits.len(); i++) text.push_back(top_digits[i]);
          text.push_back($urandom_range(1) ? digit_char(8) : digit_char($urandom_range(9)));
          if ($urandom_range(3) == 0) text.push_back(digit_char($urandom_range(9)));
        end else if (shape == 1) begin
          repeat ($urandom_range(15, 19)) text.push_back(digit_char($urandom_range(9)));
        end else if (shape == 2) begin
          repeat ($urandom_range(1, 4)) text.push_back(CharZero);
          repeat ($urandom_range(3)) text.push_back(digit_char($urandom_range(9)));
        end else begin
          repeat ($urandom_range(1, 6)) text.push_back(digit_char($urandom_range(9)));
        end
        case ($urandom_range(3))
          1: begin
            text.push_back($urandom_range(1) ? CharDot : CharComma);
            text.push_back(digit_char($urandom_range(9)));
          end
          2, 3: begin
            text.push_back($urandom_range(1) ? CharDot : CharComma);
            text.push_back($urandom_range(1) ? CharZero : digit_char($urandom_range(9)));
            text.push_back(digit_char($urandom_range(9)));
          end
          default: ;
        endcase
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 3)) text.push_back(blank_chars[$urandom_range(5)]);
        end

        // Most texts stay valid; some get one broken character, a few are noise.
        kind = $urandom_range(99);
        if (kind >= 90) begin
          text.delete();
          repeat ($urandom_range(8)) begin
            b = 8'($urandom_range(1, 255));
            text.push_back(b);
          end
        end else if (kind >= 70) begin
          pos = $urandom_range(text.size());
          b   = $urandom_range(1) ? 8'($urandom_range(1, 255))
                                  : syntax_chars[$urandom_range(7)];
          if (pos < text.size() && $urandom_range(1)) text[pos] = b;
          else text.insert(pos, b);
        end

        foreach (text[i]) pending_chars.push_back(text[i]);
        pending_chars.push_back(CharNul);
        queued += text.size() + 1;
      end

      // Hold the sender back until every outstanding amount has returned.
      do @(negedge clk_i);
      while (pending_chars.size() != 0 || in_valid_i || expected_amounts.size() != 0);
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_amounts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
